// ===== hdl/srlist_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the sorted rank list
// no dependencies

package srlist_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADRANK = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [15:0]       sort_key;
        logic [31:0]       record_tag;
        logic [CNT_W-1:0]  rank;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [CNT_W-1:0]  entry_count;
        logic [15:0]       key_out;
        logic [31:0]       tag_out;
    } out_item_t;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] tag;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic        ins_en;
        logic        rem_en;
        logic [15:0] key;
        logic [31:0] tag;
    } bcast_t;

endpackage

// ===== hdl/srlist_cell.sv =====
`timescale 1ns / 1ps
// one slot of the sorted list: holds an entry, compares it with the new key
// and shifts with its neighbors; depends on srlist_pkg

module srlist_cell (
    input  logic                aclk,
    input  srlist_pkg::bcast_t  bcast,
    input  logic                occupied,
    input  logic                at_or_after,
    input  logic                left_gt,
    input  srlist_pkg::entry_t  left_entry,
    input  srlist_pkg::entry_t  right_entry,
    output logic                gt,
    output srlist_pkg::entry_t  entry
);
    import srlist_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // stored keys are descending, so the gt flags form a prefix of the row
    assign gt    = occupied && (entry_reg.key > bcast.key);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (bcast.ins_en && !gt) begin
            if (left_gt) begin
                entry_next.key = bcast.key;
                entry_next.tag = bcast.tag;
            end else begin
                entry_next = left_entry;
            end
        end else if (bcast.rem_en && at_or_after) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hdl/sorted_rank_list.sv =====
`timescale 1ns / 1ps
// top level of the sorted rank list: row of srlist_cell slots, count and
// result register; depends on srlist_pkg and srlist_cell
//
// channel   dir  signals                      payload
// s_        in   s_valid s_ready s_data       in_item_t  (cmd, key, tag, rank)
// m_        out  m_valid m_ready m_data       out_item_t (status, count, key, tag)
//
// one command per cycle; all cells compare and shift in the same cycle
// the result appears in the output register in the cycle after the transfer
// s_ready is low only while a result waits and m_ready is low
// aresetn (synchronous) empties the list; slot contents are not cleared

module sorted_rank_list (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  srlist_pkg::in_item_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output srlist_pkg::out_item_t  m_data
);
    import srlist_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    out_item_t        out_reg;
    out_item_t        out_next;

    bcast_t           bcast;
    logic             s_fire;
    logic             full;
    logic             bad_rank;
    logic [DEPTH-1:0] occupied;
    logic [DEPTH-1:0] at_or_after;
    logic [DEPTH-1:0] sel;
    logic [DEPTH-1:0] gt;
    entry_t           entries [DEPTH];
    entry_t           sel_entry;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign bad_rank = (s_data.rank == '0) || (s_data.rank > count_reg);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign occupied[gi]    = CNT_W'(gi) < count_reg;
            assign at_or_after[gi] = CNT_W'(gi + 1) >= s_data.rank;
            assign sel[gi]         = CNT_W'(gi + 1) == s_data.rank;

            srlist_cell u_cell (
                .aclk        (aclk),
                .bcast       (bcast),
                .occupied    (occupied[gi]),
                .at_or_after (at_or_after[gi]),
                // the head slot sees a left neighbor that always outranks
                .left_gt     ((gi == 0) ? 1'b1 : gt[(gi == 0) ? 0 : gi - 1]),
                .left_entry  (entries[(gi == 0) ? 0 : gi - 1]),
                .right_entry (entries[(gi == DEPTH - 1) ? gi : gi + 1]),
                .gt          (gt[gi]),
                .entry       (entries[gi])
            );
        end
    endgenerate

    // and-or select of the slot at the requested rank
    always_comb begin
        sel_entry = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_entry = sel_entry | (sel[i] ? entries[i] : entry_t'('0));
        end
    end

    always_comb begin
        bcast.ins_en = 1'b0;
        bcast.rem_en = 1'b0;
        bcast.key    = s_data.sort_key;
        bcast.tag    = s_data.record_tag;
        count_next   = count_reg;
        out_next     = '0;
        case (s_data.cmd)
            CMD_INSERT: begin
                if (full) begin
                    out_next.status = ST_FULL;
                end else begin
                    out_next.status = ST_OK;
                    bcast.ins_en    = s_fire;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            CMD_CLEAR: begin
                out_next.status = ST_OK;
                count_next      = '0;
            end
            CMD_REMOVE, CMD_READ: begin
                if (bad_rank) begin
                    out_next.status = ST_BADRANK;
                end else begin
                    out_next.status  = ST_OK;
                    out_next.key_out = sel_entry.key;
                    out_next.tag_out = sel_entry.tag;
                    if (s_data.cmd == CMD_REMOVE) begin
                        bcast.rem_en = s_fire;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                out_next.status = ST_OK;
            end
        endcase
        out_next.entry_count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_fire) begin
            out_reg <= out_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.cmd == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the list");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.cmd == CMD_INSERT && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_error_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status != ST_OK)
        |-> (out_reg.key_out == '0 && out_reg.tag_out == '0))
        else $error("error result carries entry data");

    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (m_valid_reg && out_reg.entry_count == count_reg))
        else $error("result count differs from list count");
`endif

endmodule

// ===== sim/tb_sorted_rank_list.sv =====
`timescale 1ns / 1ps
// self-checking testbench for sorted_rank_list: directed and random command
// traffic checked against an in-bench model of the descending-key list
// depends on srlist_pkg and the sorted_rank_list rtl

module tb_sorted_rank_list;
    import srlist_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // model of the list contents
    logic [15:0] model_keys [DEPTH];
    logic [31:0] model_tags [DEPTH];
    int          model_len = 0;

    out_item_t   pending_results [$];
    int          err_count   = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    bit          quiet       = 1'b0;

    sorted_rank_list u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_item_t make_cmd(cmd_t c, logic [15:0] k, logic [31:0] t,
                                          logic [CNT_W-1:0] r);
        in_item_t it;
        it.cmd        = c;
        it.sort_key   = k;
        it.record_tag = t;
        it.rank       = r;
        return it;
    endfunction

    // applies one command to the model list and returns the result it gives
    function automatic out_item_t apply_to_list(in_item_t it);
        out_item_t res;
        int pos;
        res = '0;
        res.status = ST_OK;
        case (it.cmd)
            CMD_INSERT: begin
                if (model_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < model_len && model_keys[pos] > it.sort_key) pos++;
                    for (int i = model_len; i > pos; i--) begin
                        model_keys[i] = model_keys[i-1];
                        model_tags[i] = model_tags[i-1];
                    end
                    model_keys[pos] = it.sort_key;
                    model_tags[pos] = it.record_tag;
                    model_len++;
                end
            end
            CMD_CLEAR: begin
                model_len = 0;
            end
            default: begin
                if (it.rank == 0 || it.rank > model_len) begin
                    res.status = ST_BADRANK;
                end else begin
                    pos = it.rank - 1;
                    res.key_out = model_keys[pos];
                    res.tag_out = model_tags[pos];
                    if (it.cmd == CMD_REMOVE) begin
                        for (int i = pos; i + 1 < model_len; i++) begin
                            model_keys[i] = model_keys[i+1];
                            model_tags[i] = model_tags[i+1];
                        end
                        model_len--;
                    end
                end
            end
        endcase
        res.entry_count = model_len[CNT_W-1:0];
        return res;
    endfunction

    // starts and ends at a falling edge; valid stays up across back-to-back transfers
    task automatic push_command(in_item_t it);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_to_list(it));
        @(negedge aclk);
    endtask

    task automatic test_directed_cases();
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'd1));     // read of empty list
        push_command(make_cmd(CMD_REMOVE, 16'h0000, 32'h0, 7'd1));   // remove from empty list
        push_command(make_cmd(CMD_CLEAR, 16'hffff, 32'hffffffff, 7'd127));
        push_command(make_cmd(CMD_INSERT, 16'h0500, 32'h11111111, 7'd0));
        // second entry into a one-entry list, lower then higher key
        push_command(make_cmd(CMD_INSERT, 16'h0300, 32'h22222222, 7'd0));
        push_command(make_cmd(CMD_REMOVE, 16'h0000, 32'h0, 7'd2));
        push_command(make_cmd(CMD_INSERT, 16'h0700, 32'h33333333, 7'd0));
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'd1));
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'd2));
        // equal keys: newest goes first
        push_command(make_cmd(CMD_INSERT, 16'h0500, 32'h44444444, 7'd0));
        push_command(make_cmd(CMD_INSERT, 16'h0500, 32'h55555555, 7'd0));
        push_command(make_cmd(CMD_INSERT, 16'hffff, 32'hffffffff, 7'd0));
        push_command(make_cmd(CMD_INSERT, 16'h0000, 32'h00000000, 7'd0));
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'd0));     // rank zero
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'd5));     // next to last entry
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'd6));     // last entry
        push_command(make_cmd(CMD_REMOVE, 16'h0000, 32'h0, 7'd127));
        push_command(make_cmd(CMD_READ, 16'h1234, 32'h5678, 7'd3));
        // clear with entries, then read what was there
        push_command(make_cmd(CMD_CLEAR, 16'h0000, 32'h0, 7'd0));
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'd1));
        // remove the only entry, then use the list again
        push_command(make_cmd(CMD_INSERT, 16'h0a80, 32'hdeadbeef, 7'd0));
        push_command(make_cmd(CMD_REMOVE, 16'h0000, 32'h0, 7'd1));
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'd1));
        push_command(make_cmd(CMD_INSERT, 16'h0a81, 32'hcafef00d, 7'd0));
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'd1));
    endtask

    task automatic test_full_list();
        push_command(make_cmd(CMD_CLEAR, 16'h0000, 32'h0, 7'd0));
        for (int i = 0; i < DEPTH; i++) begin
            push_command(make_cmd(CMD_INSERT,
                ($urandom_range(0, 3) == 0) ? 16'h4000 : 16'($urandom()),
                $urandom(), 7'd0));
        end
        push_command(make_cmd(CMD_INSERT, 16'hffff, 32'hffffffff, 7'd0));  // list full
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'(DEPTH)));
        push_command(make_cmd(CMD_READ, 16'h0000, 32'h0, 7'(DEPTH + 1)));
        push_command(make_cmd(CMD_REMOVE, 16'h0000, 32'h0, 7'(DEPTH)));
        push_command(make_cmd(CMD_INSERT, 16'h0000, 32'h0, 7'd0));
        push_command(make_cmd(CMD_INSERT, 16'h0001, 32'h1, 7'd0));       // full again
        while (model_len > 0)
            push_command(make_cmd(CMD_REMOVE, 16'($urandom()), $urandom(),
                                  7'($urandom_range(1, model_len))));
    endtask

    task automatic test_random_traffic(int n_items);
        int ins_pct;
        int r;
        in_item_t it;
        ins_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: ins_pct = 80;     // fill up
                    1: ins_pct = 25;     // drain
                    default: ins_pct = 50;
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            it = make_cmd(CMD_INSERT, 16'($urandom()), $urandom(), 7'($urandom()));
            if ($urandom_range(0, 2) == 0)
                it.sort_key = 16'($urandom_range(0, 3) << 8);   // repeated keys
            r = $urandom_range(0, 99);
            if (r < 8) begin
                it.cmd = cmd_t'($urandom_range(0, 3));          // noise, any rank
            end else if (r < 10) begin
                it.cmd = CMD_CLEAR;
            end else if (r < 10 + ins_pct * 90 / 100) begin
                it.cmd = CMD_INSERT;
            end else begin
                it.cmd  = ($urandom_range(0, 1) == 0) ? CMD_REMOVE : CMD_READ;
                it.rank = (model_len > 0) ? 7'($urandom_range(1, model_len)) : 7'd1;
            end
            push_command(it);
        end
        quiet = 1'b0;
    endtask

    // result side: random stalls; none start while quiet
    always @(negedge aclk) begin : drive_ready
        logic rdy;
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = idle_len();
            rdy = (stall_left == 0);
        end else begin
            rdy = 1'b1;
        end
        m_ready <= rdy;
    end

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_data);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    err_count++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_data.entry_count);
                    err_count++;
                end
                if (m_data.key_out !== want.key_out) begin
                    $error("key_out: expected %h, got %h", want.key_out, m_data.key_out);
                    err_count++;
                end
                if (m_data.tag_out !== want.tag_out) begin
                    $error("tag_out: expected %h, got %h", want.tag_out, m_data.tag_out);
                    err_count++;
                end
            end
        end
    end

    // ends the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_full_list();
        // directed and full-list tests send about 160 commands
        test_random_traffic(240);

        s_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/srlist_pkg.sv
hdl/srlist_cell.sv
hdl/sorted_rank_list.sv
sim/tb_sorted_rank_list.sv
